/* design/assert_macros.svh */
// Assertion helpers for the RK4 datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/lrk4_pkg.sv */
package lrk4_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IO_BITS = 32;
  localparam int REG_BITS = 31;
  localparam int DT_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [1:0] {
    REG_SIGMA = 2'd0,
    REG_BETA  = 2'd1,
    REG_RHO   = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;
endpackage

/* design/lrk4_if.sv */
interface lrk4_in_if;
  logic valid;
  logic ready;
  logic signed [lrk4_pkg::IO_BITS-1:0] pos_x;
  logic signed [lrk4_pkg::IO_BITS-1:0] pos_y;
  logic signed [lrk4_pkg::IO_BITS-1:0] pos_z;
  logic [lrk4_pkg::DT_BITS-1:0] step_size;
  modport source (output valid, pos_x, pos_y, pos_z, step_size, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, step_size, output ready);
endinterface

interface lrk4_out_if;
  logic valid;
  logic ready;
  logic signed [lrk4_pkg::IO_BITS-1:0] next_x;
  logic signed [lrk4_pkg::IO_BITS-1:0] next_y;
  logic signed [lrk4_pkg::IO_BITS-1:0] next_z;
  logic overflow_flag;
  modport source (output valid, next_x, next_y, next_z, overflow_flag, input ready);
  modport sink (input valid, next_x, next_y, next_z, overflow_flag, output ready);
endinterface

interface lrk4_cfg_if;
  logic valid;
  logic ready;
  logic [lrk4_pkg::CFG_IDX_BITS-1:0] index;
  logic [lrk4_pkg::IO_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/lorenz_rk4_step.sv */
// Throughput: one request per cycle; a stall on the output freezes the whole
// pipeline, whose stages advance together under one enable.
// Every stage holds at most one multiply per coordinate and a short chain of saturating adds.
// Reset: synchronous, active low; clears stage valid bits and restores
// sigma 4.0, b 1.0 and r 48.0.
`include "assert_macros.svh"
module lorenz_rk4_step #(
  parameter int WORD_BITS = lrk4_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lrk4_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  lrk4_in_if.sink in_ch,
  lrk4_out_if.source out_ch,
  lrk4_cfg_if.sink cfg_ch
);
  localparam int W = WORD_BITS;
  localparam int PW = 2 * W + 2;
  localparam int DEPTH = 40;
  localparam int IO = lrk4_pkg::IO_BITS;
  localparam int DTB = lrk4_pkg::DT_BITS;

  typedef logic signed [W-1:0] word_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef struct packed {
    word_t x; word_t y; word_t z;
    word_t px; word_t py; word_t pz;
    word_t ax; word_t ay; word_t az;
    word_t bx; word_t by; word_t bz;
    word_t tx; word_t ty; word_t tz;
    logic [DTB-1:0] dt;
    logic ovf;
  } stage_t;

  localparam prod_t WMAXP = prod_t'({1'b0, {(W-1){1'b1}}});
  localparam prod_t WMINP = -WMAXP - prod_t'(1);
  localparam word_t WMAX = word_t'(WMAXP);
  localparam word_t WMIN = word_t'(WMINP);
  localparam prod_t DIV3M = ((prod_t'(1) <<< (W + 1)) / prod_t'(3)) + prod_t'(1);

  logic [lrk4_pkg::REG_BITS-1:0] sigma_r, beta_r, rho_r;
  stage_t st_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic adv;
  word_t sg, bg, rh;
  logic cov;

  assign adv = out_ch.ready || !vld_r[DEPTH-1];
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= lrk4_pkg::REG_BITS'(262144);
      beta_r <= lrk4_pkg::REG_BITS'(65536);
      rho_r <= lrk4_pkg::REG_BITS'(3145728);
    end else if (cfg_ch.valid) begin
      unique case (lrk4_pkg::reg_idx_t'(cfg_ch.index))
        lrk4_pkg::REG_SIGMA: sigma_r <= cfg_ch.data[lrk4_pkg::REG_BITS-1:0];
        lrk4_pkg::REG_BETA: beta_r <= cfg_ch.data[lrk4_pkg::REG_BITS-1:0];
        lrk4_pkg::REG_RHO: rho_r <= cfg_ch.data[lrk4_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  function automatic word_t satp(input prod_t v, inout logic o);
    if (v > WMAXP) begin o = 1'b1; return WMAX; end
    if (v < WMINP) begin o = 1'b1; return WMIN; end
    return word_t'(v);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b, inout logic o);
    return satp(prod_t'(a) + prod_t'(b), o);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b, inout logic o);
    return satp(prod_t'(a) - prod_t'(b), o);
  endfunction

  function automatic word_t qmul(input word_t a, input word_t b, input int s,
                                 inout logic o);
    prod_t p;
    p = (prod_t'(a) * prod_t'(b) + (prod_t'(1) <<< (s - 1))) >>> s;
    return satp(p, o);
  endfunction

  function automatic word_t unreg(input logic [lrk4_pkg::REG_BITS-1:0] v, inout logic o);
    return satp(prod_t'($unsigned(v)), o);
  endfunction

  function automatic word_t div6(input word_t t);
    prod_t m;
    prod_t q;
    m = (t < 0) ? -prod_t'(t) : prod_t'(t);
    q = (((m + prod_t'(3)) >>> 1) * DIV3M) >>> (W + 1);
    return (t < 0) ? word_t'(-q) : word_t'(q);
  endfunction

  always_comb begin
    cov = 1'b0;
    sg = unreg(sigma_r, cov);
    bg = unreg(beta_r, cov);
    rh = unreg(rho_r, cov);
  end

  // The user must keep configuration static while requests are in flight; the block
  // does not enforce it. b*r is computed combinationally and registered.
  word_t br;
  logic brov;
  word_t br_r;
  logic brov_r;
  always_comb begin
    brov = 1'b0;
    br = qmul(bg, rh, FRAC_BITS, brov);
  end

  always_ff @(posedge clk) begin
    br_r <= br;
    brov_r <= brov;
  end

  // Per-stage operation. Each RK phase uses 9 stages for its derivative and
  // advance; the final combine uses the last three.
  function automatic stage_t step(input stage_t s, input int k);
    stage_t n;
    logic o;
    int ph;
    int sub;
    int sh;
    n = s;
    o = s.ovf;
    ph = k / 9;
    sub = k % 9;
    sh = (ph < 2) ? DTB + 1 : DTB;
    if (ph < 4) begin
      unique case (sub)
        0: begin n.tx = ssub(s.y, s.x, o); n.ty = ssub('0, s.y, o); end
        1: begin n.tx = qmul(sg, s.tx, FRAC_BITS, o); end
        2: begin n.tz = qmul(s.x, s.z, FRAC_BITS, o); end
        3: begin n.ty = ssub(s.ty, s.tz, o); end
        4: begin n.tz = qmul(bg, s.z, FRAC_BITS, o); end
        5: begin n.tz = ssub('0, s.tz, o); end
        6: begin n.tz = sadd(s.tz, qmul(s.x, s.y, FRAC_BITS, o), o); end
        7: begin
          n.tz = ssub(s.tz, br_r, o);
          o = o | brov_r;
          if (ph == 0) begin n.ax = s.tx; n.ay = s.ty; n.az = n.tz; end
          else if (ph == 1) begin
            n.ax = sadd(s.ax, sadd(s.tx, s.tx, o), o);
            n.ay = sadd(s.ay, sadd(s.ty, s.ty, o), o);
            n.az = sadd(s.az, sadd(n.tz, n.tz, o), o);
          end else if (ph == 2) begin
            n.bx = sadd(s.tx, s.tx, o);
            n.by = sadd(s.ty, s.ty, o);
            n.bz = sadd(n.tz, n.tz, o);
          end else begin
            n.bx = sadd(s.bx, s.tx, o);
            n.by = sadd(s.by, s.ty, o);
            n.bz = sadd(s.bz, n.tz, o);
          end
        end
        default: begin
          if (ph < 3) begin
            n.x = sadd(s.px, qmul(s.tx, word_t'(s.dt), sh, o), o);
            n.y = sadd(s.py, qmul(s.ty, word_t'(s.dt), sh, o), o);
            n.z = sadd(s.pz, qmul(s.tz, word_t'(s.dt), sh, o), o);
          end else begin
            n.ax = sadd(s.ax, s.bx, o);
            n.ay = sadd(s.ay, s.by, o);
            n.az = sadd(s.az, s.bz, o);
          end
        end
      endcase
    end else begin
      unique case (sub)
        0: begin
          n.ax = qmul(s.ax, word_t'(s.dt), DTB, o);
          n.ay = qmul(s.ay, word_t'(s.dt), DTB, o);
          n.az = qmul(s.az, word_t'(s.dt), DTB, o);
        end
        1: begin
          n.ax = div6(s.ax);
          n.ay = div6(s.ay);
          n.az = div6(s.az);
        end
        default: begin
          n.x = sadd(s.px, s.ax, o);
          n.y = sadd(s.py, s.ay, o);
          n.z = sadd(s.pz, s.az, o);
        end
      endcase
    end
    n.ovf = o;
    return n;
  endfunction

  function automatic word_t inw(input logic signed [IO-1:0] v, inout logic o);
    return satp(prod_t'(v), o);
  endfunction

  stage_t s0;
  always_comb begin
    logic o;
    o = cov;
    s0 = '0;
    s0.x = inw(in_ch.pos_x, o);
    s0.y = inw(in_ch.pos_y, o);
    s0.z = inw(in_ch.pos_z, o);
    s0.px = s0.x; s0.py = s0.y; s0.pz = s0.z;
    s0.dt = in_ch.step_size;
    s0.ovf = o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0;
      for (int i = 1; i < DEPTH; i++) st_r[i] <= step(st_r[i-1], i - 1);
    end
  end

  function automatic logic signed [IO-1:0] o32(input word_t v, inout logic o);
    prod_t m;
    prod_t lo;
    m = prod_t'({1'b0, {(IO-1){1'b1}}});
    lo = -m - prod_t'(1);
    if (prod_t'(v) > m) begin o = 1'b1; return IO'(m); end
    if (prod_t'(v) < lo) begin o = 1'b1; return IO'(lo); end
    return IO'(v);
  endfunction

  always_comb begin
    logic o;
    o = st_r[DEPTH-1].ovf;
    out_ch.next_x = o32(st_r[DEPTH-1].x, o);
    out_ch.next_y = o32(st_r[DEPTH-1].y, o);
    out_ch.next_z = o32(st_r[DEPTH-1].z, o);
    out_ch.overflow_flag = o;
  end
  assign out_ch.valid = vld_r[DEPTH-1];

  `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
    "result dropped while stalled")
  `ASSERT_NEXT(a_move, clk, rst_n, adv && in_ch.valid, vld_r[0],
    "accepted request not captured")
  `ASSERT_CLK(a_rdy, clk, rst_n, in_ch.ready == (out_ch.ready || !out_ch.valid),
    "input ready does not follow output stall")
endmodule

/* verif/lorenz_rk4_step_test.sv */
module lorenz_rk4_step_test;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic ovf;
  } rk4_result_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0] dt;
    bit typed;
    rk4_result_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  lrk4_in_if in_if();
  lrk4_out_if out_if();
  lrk4_cfg_if cfg_if();

  lorenz_rk4_step i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  logic [30:0] sigma_q;
  logic [30:0] beta_q;
  logic [30:0] rho_q;
  bit sat_hit;
  rk4_result_t pending_steps[$];
  int fail_count;
  int cycle_count;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clampw(longint v);
    if (v > WMAX) begin
      sat_hit = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat_hit = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int s);
    longint p;
    p = a * b + (longint'(1) << (s - 1));
    return clampw(p >>> s);
  endfunction

  function automatic longint div_six(longint t);
    longint q;
    q = ((t < 0 ? -t : t) + 3) / 6;
    return t < 0 ? -q : q;
  endfunction

  function automatic void lorenz_deriv(input longint p[3], input longint br,
                                       output longint k[3]);
    k[0] = fx_mul(longint'(sigma_q), clampw(p[1] - p[0]), lrk4_pkg::FRAC_BITS_DEF);
    k[1] = clampw(clampw(-p[1]) - fx_mul(p[0], p[2], lrk4_pkg::FRAC_BITS_DEF));
    k[2] = clampw(clampw(clampw(-fx_mul(longint'(beta_q), p[2], lrk4_pkg::FRAC_BITS_DEF))
                  + fx_mul(p[0], p[1], lrk4_pkg::FRAC_BITS_DEF)) - br);
  endfunction

  function automatic rk4_result_t rk4_advance(logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] z, logic [15:0] dt);
    longint p[3], q[3], k1[3], k2[3], k3[3], k4[3], n[3];
    longint br, s, dtl;
    rk4_result_t r;
    sat_hit = 1'b0;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    dtl = dt;
    br = fx_mul(longint'(beta_q), longint'(rho_q), lrk4_pkg::FRAC_BITS_DEF);
    lorenz_deriv(p, br, k1);
    for (int i = 0; i < 3; i++)
      q[i] = clampw(p[i] + fx_mul(k1[i], dtl, lrk4_pkg::DT_BITS + 1));
    lorenz_deriv(q, br, k2);
    for (int i = 0; i < 3; i++)
      q[i] = clampw(p[i] + fx_mul(k2[i], dtl, lrk4_pkg::DT_BITS + 1));
    lorenz_deriv(q, br, k3);
    for (int i = 0; i < 3; i++)
      q[i] = clampw(p[i] + fx_mul(k3[i], dtl, lrk4_pkg::DT_BITS));
    lorenz_deriv(q, br, k4);
    for (int i = 0; i < 3; i++) begin
      s = clampw(clampw(k1[i] + clampw(k2[i] + k2[i]))
                 + clampw(clampw(k3[i] + k3[i]) + k4[i]));
      n[i] = clampw(p[i] + div_six(fx_mul(s, dtl, lrk4_pkg::DT_BITS)));
    end
    r.nx = n[0][31:0];
    r.ny = n[1][31:0];
    r.nz = n[2][31:0];
    r.ovf = sat_hit;
    return r;
  endfunction

  function automatic void queue_expected(rk4_result_t r);
    pending_steps.insert(pending_steps.size(), r);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(lrk4_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      lrk4_pkg::REG_SIGMA: sigma_q = value[30:0];
      lrk4_pkg::REG_BETA: beta_q = value[30:0];
      lrk4_pkg::REG_RHO: rho_q = value[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_step(stim_row_t row);
    int g;
    in_if.valid <= 1'b1;
    in_if.pos_x <= row.x;
    in_if.pos_y <= row.y;
    in_if.pos_z <= row.z;
    in_if.step_size <= row.dt;
    do @(posedge clk); while (!in_if.ready);
    if (row.typed) queue_expected(row.res);
    else queue_expected(rk4_advance(row.x, row.y, row.z, row.dt));
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic random_steps(int count);
    stim_row_t row;
    row.typed = 1'b0;
    for (int i = 0; i < count; i++) begin
      no_idle = (i % 40) < 8;
      if ($urandom_range(0, 99) < 75) begin
        row.x = $signed($urandom_range(0, 6553600)) - 32'sd3276800;
        row.y = $signed($urandom_range(0, 6553600)) - 32'sd3276800;
        row.z = $signed($urandom_range(0, 6553600)) - 32'sd3276800;
        row.dt = 16'($urandom_range(0, 4096));
      end else begin
        row.x = $urandom;
        row.y = $urandom;
        row.z = $urandom;
        row.dt = 16'($urandom_range(0, 65535));
      end
      send_step(row);
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    rk4_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h ovf=%b", $time,
                 out_if.next_x, out_if.next_y, out_if.next_z, out_if.overflow_flag);
        fail_count++;
      end else begin
        e = pending_steps.pop_front();
        if (out_if.next_x !== e.nx) begin
          $display("%0t: next_x expected %h actual %h", $time, e.nx, out_if.next_x);
          fail_count++;
        end
        if (out_if.next_y !== e.ny) begin
          $display("%0t: next_y expected %h actual %h", $time, e.ny, out_if.next_y);
          fail_count++;
        end
        if (out_if.next_z !== e.nz) begin
          $display("%0t: next_z expected %h actual %h", $time, e.nz, out_if.next_z);
          fail_count++;
        end
        if (out_if.overflow_flag !== e.ovf) begin
          $display("%0t: overflow_flag expected %b actual %b", $time, e.ovf,
                   out_if.overflow_flag);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lorenz_rk4_step verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    cycle_count = 0;
    fail_count = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.step_size = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lrk4_pkg::REG_SIGMA;
    cfg_if.data = '0;
    sigma_q = 31'd262144;
    beta_q = 31'd65536;
    rho_q = 31'd3145728;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    table_rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 16'd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
      '{32'sd65536, 32'sd65536, 32'sd0, 16'd0, 1'b1,
        '{32'sd65536, 32'sd65536, 32'sd0, 1'b0}},
      '{32'sd65536, 32'sd131072, 32'sd196608, 16'd655, 1'b0, '{0, 0, 0, 0}},
      '{32'sd0, 32'sd0, 32'sd0, 16'hFFFF, 1'b0, '{0, 0, 0, 0}},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0, '{0, 0, 0, 0}},
      '{32'h80000000, 32'h80000000, 32'h80000000, 16'hFFFF, 1'b0, '{0, 0, 0, 0}},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'd1, 1'b0, '{0, 0, 0, 0}},
      '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 1'b0, '{0, 0, 0, 0}},
      '{32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 16'd1, 1'b0, '{0, 0, 0, 0}},
      '{32'sd655360, -32'sd655360, 32'sd3276800, 16'd6554, 1'b0, '{0, 0, 0, 0}},
      '{-32'sd1310720, 32'sd1966080, -32'sd327680, 16'd65535, 1'b0, '{0, 0, 0, 0}},
      '{32'sd16777216, 32'sd16777216, 32'sd16777216, 16'd1000, 1'b0, '{0, 0, 0, 0}}
    };
    foreach (table_rows[i]) send_step(table_rows[i]);
    random_steps(60);

    wait_idle();
    write_reg(lrk4_pkg::REG_SIGMA, 32'h0);
    write_reg(lrk4_pkg::REG_BETA, 32'h0);
    write_reg(lrk4_pkg::REG_RHO, 32'h0);
    random_steps(70);

    wait_idle();
    write_reg(lrk4_pkg::REG_SIGMA, 32'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_BETA, 32'h7FFFFFFF);
    write_reg(lrk4_pkg::REG_RHO, 32'h7FFFFFFF);
    random_steps(70);

    wait_idle();
    write_reg(lrk4_pkg::REG_SIGMA, 32'h80000000 | 32'd655360);
    write_reg(lrk4_pkg::REG_BETA, 32'hFFFFFFFF & 32'h8002AAAB);
    write_reg(lrk4_pkg::REG_RHO, 32'h80000000 | 32'd1835008);
    write_reg(lrk4_pkg::REG_NONE, $urandom);
    random_steps(70);

    for (int ph = 0; ph < 2; ph++) begin
      wait_idle();
      write_reg(lrk4_pkg::REG_SIGMA, $urandom_range(0, 1048576));
      write_reg(lrk4_pkg::REG_BETA, $urandom_range(0, 262144));
      write_reg(lrk4_pkg::REG_RHO, $urandom);
      random_steps(70);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("lorenz_rk4_step verification clean");
    end else begin
      $display("lorenz_rk4_step verification failed");
    end
    $finish;
  end
endmodule
